>>> hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked property checks used by the datapath; they compile away when
// NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS
`define MCO_ASSERT(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("assertion failed");
`define MCO_NEVER(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
      else $error("forbidden condition seen");
`else
`define MCO_ASSERT(lbl, clk, rst, prop)
`define MCO_NEVER(lbl, clk, rst, cond)
`endif

`endif

>>> hw/rtl/mco_pkg.sv
// ----------------------------------------------------------------------------
// mco_pkg
// Types, codes and widths shared by the matrix chain order cost block.
// ----------------------------------------------------------------------------
`default_nettype none

package mco_pkg;

   localparam int MAX_MATRICES_DEF = 64;
   localparam int DIM_BITS_DEF     = 16;

   localparam int DIM_VALUE_W = 16;
   localparam int MIN_COST_W  = 63;
   localparam int SPLIT_W     = 7;
   localparam int STATUS_W    = 2;
   localparam int COST_W      = 64;

   localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_SATURATED = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_TOO_MANY  = 2'd2;
   localparam logic [STATUS_W-1:0] STATUS_NO_MATRIX = 2'd3;

   typedef enum logic [2:0] {
      ST_LOAD,
      ST_DECIDE,
      ST_CELL_RD,
      ST_CELL_MUL,
      ST_ITER,
      ST_DRAIN,
      ST_WRITE,
      ST_EMIT
   } state_type;

   typedef enum logic [1:0] {
      RES_FILL,
      RES_SINGLE,
      RES_TOO_MANY,
      RES_NONE
   } res_kind_type;

   typedef struct packed {
      logic         load;
      logic         cell_first;
      logic         cell_rd;
      logic         cell_mul;
      logic         issue;
      logic         write;
      logic         emit;
      res_kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic too_many;
      logic count_lt2;
      logic count_eq2;
      logic last_k;
      logic last_len;
      logic pipe_busy;
      logic rsp_free;
   } sts_type;

endpackage

`default_nettype wire

>>> hw/rtl/mco_req_if.sv
// ----------------------------------------------------------------------------
// mco_req_if
// Input channel: one chain dimension per item, the last one flagged.
// ----------------------------------------------------------------------------
`default_nettype none

interface mco_req_if;
   logic                              valid;
   logic                              ready;
   logic [mco_pkg::DIM_VALUE_W-1:0]   dim_value;
   logic                              last_dim;

   modport source (output valid, output dim_value, output last_dim, input ready);
   modport sink   (input valid, input dim_value, input last_dim, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mco_rsp_if.sv
// ----------------------------------------------------------------------------
// mco_rsp_if
// Result channel: minimum cost, best outermost split and status.
// ----------------------------------------------------------------------------
`default_nettype none

interface mco_rsp_if;
   logic                             valid;
   logic                             ready;
   logic [mco_pkg::MIN_COST_W-1:0]   min_cost;
   logic [mco_pkg::SPLIT_W-1:0]      best_split;
   logic [mco_pkg::STATUS_W-1:0]     status;

   modport source (output valid, output min_cost, output best_split, output status,
                   input ready);
   modport sink   (input valid, input min_cost, input best_split, input status,
                   output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mco_ram.sv
// ----------------------------------------------------------------------------
// mco_ram
// Generic RAM: one write port, two read ports with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mco_ram #(
   parameter  int WIDTH = 8,
   parameter  int DEPTH = 16,
   localparam int AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AddrW-1:0] wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic [AddrW-1:0] rd_addr_a,
   output logic [WIDTH-1:0] rd_data_a,
   input  logic [AddrW-1:0] rd_addr_b,
   output logic [WIDTH-1:0] rd_data_b
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_a_ff <= mem_ff[rd_addr_a];
      rd_b_ff <= mem_ff[rd_addr_b];
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule

`default_nettype wire

>>> hw/rtl/mco_ctrl.sv
// ----------------------------------------------------------------------------
// mco_ctrl
// Sequencer: loads dimensions, walks the interval table cell by cell and
// issues one split point per cycle, then hands the result to the output.
// ----------------------------------------------------------------------------
`default_nettype none

module mco_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_last,
   output logic             req_ready,
   input  mco_pkg::sts_type sts,
   output mco_pkg::cmd_type cmd
);

   mco_pkg::state_type    state_ff, state_in;
   mco_pkg::res_kind_type kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mco_pkg::ST_LOAD;
         kind_ff  <= mco_pkg::RES_NONE;
      end else begin
         state_ff <= state_in;
         kind_ff  <= kind_in;
      end
   end

   always_comb begin
      state_in       = state_ff;
      kind_in        = kind_ff;
      req_ready      = 1'b0;
      cmd            = '0;
      cmd.kind       = kind_ff;
      unique case (state_ff)
         mco_pkg::ST_LOAD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               if (req_last) begin
                  state_in = mco_pkg::ST_DECIDE;
               end
            end
         end
         mco_pkg::ST_DECIDE: begin
            if (sts.too_many) begin
               kind_in  = mco_pkg::RES_TOO_MANY;
               state_in = mco_pkg::ST_EMIT;
            end else if (sts.count_lt2) begin
               kind_in  = mco_pkg::RES_NONE;
               state_in = mco_pkg::ST_EMIT;
            end else if (sts.count_eq2) begin
               kind_in  = mco_pkg::RES_SINGLE;
               state_in = mco_pkg::ST_EMIT;
            end else begin
               kind_in        = mco_pkg::RES_FILL;
               cmd.cell_first = 1'b1;
               state_in       = mco_pkg::ST_CELL_RD;
            end
         end
         mco_pkg::ST_CELL_RD: begin
            cmd.cell_rd = 1'b1;
            state_in    = mco_pkg::ST_CELL_MUL;
         end
         mco_pkg::ST_CELL_MUL: begin
            cmd.cell_mul = 1'b1;
            state_in     = mco_pkg::ST_ITER;
         end
         mco_pkg::ST_ITER: begin
            cmd.issue = 1'b1;
            if (sts.last_k) begin
               state_in = mco_pkg::ST_DRAIN;
            end
         end
         mco_pkg::ST_DRAIN: begin
            if (!sts.pipe_busy) begin
               state_in = mco_pkg::ST_WRITE;
            end
         end
         mco_pkg::ST_WRITE: begin
            cmd.write = 1'b1;
            // The whole-chain interval is the last cell of the last length.
            if (sts.last_len) begin
               state_in = mco_pkg::ST_EMIT;
            end else begin
               state_in = mco_pkg::ST_CELL_RD;
            end
         end
         mco_pkg::ST_EMIT: begin
            if (sts.rsp_free) begin
               cmd.emit = 1'b1;
               state_in = mco_pkg::ST_LOAD;
            end
         end
         default: begin
            state_in = mco_pkg::ST_LOAD;
         end
      endcase
   end

endmodule

`default_nettype wire

>>> hw/rtl/mco_dpath.sv
// ----------------------------------------------------------------------------
// mco_dpath
// Datapath: dimension store, cost table, loop counters, the split-point
// pipeline with its running minimum, and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mco_dpath #(
   parameter int MAX_MATRICES = mco_pkg::MAX_MATRICES_DEF,
   parameter int DIM_BITS     = mco_pkg::DIM_BITS_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  mco_pkg::cmd_type                   cmd,
   output mco_pkg::sts_type                   sts,
   input  logic [mco_pkg::DIM_VALUE_W-1:0]    dim_value,
   input  logic                               rsp_ready,
   output logic                               rsp_valid,
   output logic [mco_pkg::MIN_COST_W-1:0]     min_cost,
   output logic [mco_pkg::SPLIT_W-1:0]        best_split,
   output logic [mco_pkg::STATUS_W-1:0]       status
);

   localparam int MaxDims   = MAX_MATRICES + 1;
   localparam int CntW      = $clog2(MaxDims + 1);
   localparam int DimAw     = $clog2(MaxDims);
   localparam int IdxW      = $clog2(MAX_MATRICES + 1);
   localparam int CellDepth = MAX_MATRICES * MAX_MATRICES;
   localparam int CellAw    = (CellDepth > 1) ? $clog2(CellDepth) : 1;
   localparam int LoadW     = (DIM_BITS < mco_pkg::DIM_VALUE_W) ? DIM_BITS
                                                                : mco_pkg::DIM_VALUE_W;
   localparam int ProdW     = 2 * DIM_BITS;
   localparam int FullW     = 3 * DIM_BITS;
   localparam int CostW     = mco_pkg::COST_W;
   localparam int SumW      = CostW + 1;

   // Loading and loop control
   logic [CntW-1:0]   count_ff, count_in;
   logic              too_many_ff, too_many_in;
   logic [IdxW-1:0]   len_ff, len_in;
   logic [IdxW-1:0]   i_ff, i_in;
   logic [IdxW-1:0]   k_ff, k_in;
   logic [IdxW-1:0]   n, j;
   logic [CellAw-1:0] addr_a_ff, addr_a_in;
   logic [CellAw-1:0] addr_b_ff, addr_b_in;
   logic [CellAw-1:0] addr_w_ff, addr_w_in;
   logic [ProdW-1:0]  prod_ff;
   int                ii, jj;

   // Memories
   logic              dim_wr_en;
   logic [DimAw-1:0]  dim_rd_a, dim_rd_b;
   logic [DIM_BITS-1:0] dim_a, dim_b;
   logic [CostW-1:0]  cost_a, cost_b;

   // Split-point pipeline
   logic              v1_ff, v2_ff, v3_ff;
   logic              dl1_ff, dr1_ff;
   logic [IdxW-1:0]   k1_ff, k2_ff, k3_ff;
   logic [ProdW-1:0]  mlo2_ff, mhi2_ff;
   logic [CostW-1:0]  ab2_ff, ab3_ff;
   logic              flag2_ff, flag3_ff;
   logic [FullW-1:0]  p3_ff;
   logic [CostW-2:0]  left_c, right_c;
   logic [SumW-1:0]   total;
   logic [CostW-1:0]  cand;
   logic              sat;

   // Running minimum and result
   logic              have_ff, have_in;
   logic [CostW-1:0]  best_ff, best_in;
   logic [IdxW-1:0]   best_k_ff, best_k_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [mco_pkg::MIN_COST_W-1:0] min_cost_ff;
   logic [mco_pkg::SPLIT_W-1:0]    best_split_ff;
   logic [mco_pkg::STATUS_W-1:0]   status_ff;
   logic              rsp_free;

   assign n        = IdxW'(count_ff - CntW'(1));
   assign j        = IdxW'(len_ff + i_ff - 1'b1);
   assign ii       = int'(i_ff);
   assign jj       = int'(j);
   assign rsp_free = !rsp_valid_ff || rsp_ready;

   assign sts.too_many  = too_many_ff;
   assign sts.count_lt2 = count_ff < CntW'(2);
   assign sts.count_eq2 = count_ff == CntW'(2);
   assign sts.last_k    = IdxW'(k_ff + 1'b1) == j;
   assign sts.last_len  = len_ff == n;
   assign sts.pipe_busy = v1_ff || v2_ff || v3_ff;
   assign sts.rsp_free  = rsp_free;

   // ------------------------------------------------------------------
   // Memories
   // ------------------------------------------------------------------
   assign dim_wr_en = cmd.load && (count_ff < CntW'(MaxDims));
   assign dim_rd_a  = cmd.issue ? DimAw'(k_ff) : DimAw'(i_ff - 1'b1);
   assign dim_rd_b  = DimAw'(j);

   mco_ram #(
      .WIDTH (DIM_BITS),
      .DEPTH (MaxDims)
   ) u_dim_ram (
      .clock     (clock),
      .wr_en     (dim_wr_en),
      .wr_addr   (DimAw'(count_ff)),
      .wr_data   (DIM_BITS'(dim_value[LoadW-1:0])),
      .rd_addr_a (dim_rd_a),
      .rd_data_a (dim_a),
      .rd_addr_b (dim_rd_b),
      .rd_data_b (dim_b)
   );

   mco_ram #(
      .WIDTH (CostW),
      .DEPTH (CellDepth)
   ) u_cost_ram (
      .clock     (clock),
      .wr_en     (cmd.write),
      .wr_addr   (addr_w_ff),
      .wr_data   (best_ff),
      .rd_addr_a (addr_a_ff),
      .rd_data_a (cost_a),
      .rd_addr_b (addr_b_ff),
      .rd_data_b (cost_b)
   );

   // ------------------------------------------------------------------
   // Counters and addresses
   // ------------------------------------------------------------------
   always_comb begin
      count_in    = count_ff;
      too_many_in = too_many_ff;
      if (cmd.emit) begin
         count_in    = '0;
         too_many_in = 1'b0;
      end else if (cmd.load) begin
         if (count_ff < CntW'(MaxDims)) begin
            count_in = CntW'(count_ff + 1'b1);
         end else begin
            too_many_in = 1'b1;
         end
      end

      len_in = len_ff;
      i_in   = i_ff;
      if (cmd.cell_first) begin
         len_in = IdxW'(2);
         i_in   = IdxW'(1);
      end else if (cmd.write) begin
         if (j == n) begin
            len_in = IdxW'(len_ff + 1'b1);
            i_in   = IdxW'(1);
         end else begin
            i_in = IdxW'(i_ff + 1'b1);
         end
      end

      addr_a_in = addr_a_ff;
      addr_b_in = addr_b_ff;
      addr_w_in = addr_w_ff;
      k_in      = k_ff;
      if (cmd.cell_rd) begin
         // Left operand starts at (i,i), right operand at (i+1,j).
         addr_a_in = CellAw'((ii - 1) * MAX_MATRICES + ii - 1);
         addr_b_in = CellAw'(ii * MAX_MATRICES + jj - 1);
         addr_w_in = CellAw'((ii - 1) * MAX_MATRICES + jj - 1);
      end else if (cmd.cell_mul) begin
         k_in = i_ff;
      end else if (cmd.issue) begin
         // Left walks along a row, right walks down a column.
         addr_a_in = CellAw'(addr_a_ff + 1'b1);
         addr_b_in = CellAw'(addr_b_ff + CellAw'(MAX_MATRICES));
         k_in      = IdxW'(k_ff + 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff    <= '0;
         too_many_ff <= 1'b0;
      end else begin
         count_ff    <= count_in;
         too_many_ff <= too_many_in;
      end
      len_ff    <= len_in;
      i_ff      <= i_in;
      k_ff      <= k_in;
      addr_a_ff <= addr_a_in;
      addr_b_ff <= addr_b_in;
      addr_w_ff <= addr_w_in;
      if (cmd.cell_mul) begin
         prod_ff <= ProdW'(dim_a) * ProdW'(dim_b);
      end
   end

   // ------------------------------------------------------------------
   // Split-point pipeline
   // ------------------------------------------------------------------
   // Diagonal cells cost nothing, so their table entries are ignored and zero is used.
   assign left_c  = dl1_ff ? '0 : cost_a[CostW-2:0];
   assign right_c = dr1_ff ? '0 : cost_b[CostW-2:0];

   assign total = {1'b0, ab3_ff} + SumW'(p3_ff);
   assign sat   = flag3_ff || (total[SumW-1:SumW-2] != 2'b00);
   assign cand  = sat ? '1 : total[CostW-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= cmd.issue;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
      dl1_ff   <= k_ff == i_ff;
      dr1_ff   <= IdxW'(k_ff + 1'b1) == j;
      k1_ff    <= k_ff;
      mlo2_ff  <= ProdW'(prod_ff[DIM_BITS-1:0]) * ProdW'(dim_a);
      mhi2_ff  <= ProdW'(prod_ff[ProdW-1:DIM_BITS]) * ProdW'(dim_a);
      ab2_ff   <= {1'b0, left_c} + {1'b0, right_c};
      flag2_ff <= (!dl1_ff && cost_a[CostW-1]) || (!dr1_ff && cost_b[CostW-1]);
      k2_ff    <= k1_ff;
      p3_ff    <= {mhi2_ff, {DIM_BITS{1'b0}}} + FullW'(mlo2_ff);
      ab3_ff   <= ab2_ff;
      flag3_ff <= flag2_ff;
      k3_ff    <= k2_ff;
   end

   // Strictly-less keeps the smallest split among equal costs.
   always_comb begin
      have_in   = have_ff;
      best_in   = best_ff;
      best_k_in = best_k_ff;
      if (cmd.cell_mul) begin
         have_in = 1'b0;
      end else if (v3_ff && (!have_ff || (cand < best_ff))) begin
         have_in   = 1'b1;
         best_in   = cand;
         best_k_in = k3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_ff <= 1'b0;
      end else begin
         have_ff <= have_in;
      end
      best_ff   <= best_in;
      best_k_ff <= best_k_in;
   end

   // ------------------------------------------------------------------
   // Result register
   // ------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (cmd.emit) begin
         unique case (cmd.kind)
            mco_pkg::RES_FILL: begin
               min_cost_ff   <= best_ff[CostW-2:0];
               best_split_ff <= mco_pkg::SPLIT_W'(best_k_ff);
               status_ff     <= best_ff[CostW-1] ? mco_pkg::STATUS_SATURATED
                                                 : mco_pkg::STATUS_OK;
            end
            mco_pkg::RES_SINGLE: begin
               min_cost_ff   <= '0;
               best_split_ff <= '0;
               status_ff     <= mco_pkg::STATUS_OK;
            end
            mco_pkg::RES_TOO_MANY: begin
               min_cost_ff   <= '0;
               best_split_ff <= '0;
               status_ff     <= mco_pkg::STATUS_TOO_MANY;
            end
            mco_pkg::RES_NONE: begin
               min_cost_ff   <= '0;
               best_split_ff <= '0;
               status_ff     <= mco_pkg::STATUS_NO_MATRIX;
            end
            default: begin
               min_cost_ff   <= '0;
               best_split_ff <= '0;
               status_ff     <= mco_pkg::STATUS_NO_MATRIX;
            end
         endcase
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign min_cost   = min_cost_ff;
   assign best_split = best_split_ff;
   assign status     = status_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `MCO_ASSERT(a_write_after_drain, clock, reset, cmd.write |-> !sts.pipe_busy)
   `MCO_ASSERT(a_emit_into_free_slot, clock, reset, cmd.emit |-> rsp_free)
   `MCO_NEVER(a_count_in_range, clock, reset, count_ff > CntW'(MaxDims))
   `MCO_ASSERT(a_split_in_interval, clock, reset, cmd.issue |-> (k_ff >= i_ff && k_ff < j))

endmodule

`default_nettype wire

>>> hw/rtl/matrix_chain_order_cost.sv
// Dimension items are taken one per cycle while loading. Chains that are too long,
// empty or of one matrix skip the fill. The fill runs through the single
// split-point pipeline, one split per cycle, and each cell also needs setup, a
// pipeline drain and a cost table write before the next cell starts. Reset clears
// the dimension count, state and valid flags; the stores need no clearing.
// ----------------------------------------------------------------------------
// matrix_chain_order_cost
// Loads a chain's dimensions and returns the minimum scalar multiplication
// count with the best outermost split, using interval dynamic programming.
// ----------------------------------------------------------------------------
`default_nettype none

module matrix_chain_order_cost #(
   parameter int MAX_MATRICES = mco_pkg::MAX_MATRICES_DEF,
   parameter int DIM_BITS     = mco_pkg::DIM_BITS_DEF
) (
   input  logic      clock,
   input  logic      reset,
   mco_req_if.sink   req_ch,
   mco_rsp_if.source rsp_ch
);

   mco_pkg::cmd_type cmd;
   mco_pkg::sts_type sts;
   logic             req_ready;
   logic             rsp_valid;
   logic [mco_pkg::MIN_COST_W-1:0] min_cost;
   logic [mco_pkg::SPLIT_W-1:0]    best_split;
   logic [mco_pkg::STATUS_W-1:0]   status;

   mco_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_last  (req_ch.last_dim),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   mco_dpath #(
      .MAX_MATRICES (MAX_MATRICES),
      .DIM_BITS     (DIM_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .sts        (sts),
      .dim_value  (req_ch.dim_value),
      .rsp_ready  (rsp_ch.ready),
      .rsp_valid  (rsp_valid),
      .min_cost   (min_cost),
      .best_split (best_split),
      .status     (status)
   );

   assign req_ch.ready      = req_ready;
   assign rsp_ch.valid      = rsp_valid;
   assign rsp_ch.min_cost   = min_cost;
   assign rsp_ch.best_split = best_split;
   assign rsp_ch.status     = status;

endmodule

`default_nettype wire

>>> dv/tb_matrix_chain_order_cost.sv
// ----------------------------------------------------------------------------
// tb_matrix_chain_order_cost
// Self-checking bench for the matrix chain order cost block. Dimension items
// are driven with random valid gaps and result back-pressure. A behavioral
// interval DP predicts the result of each chain unless a directed row gives it,
// and every result is checked field by field in order of arrival.
// ----------------------------------------------------------------------------
module tb_matrix_chain_order_cost;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAXM         = mco_pkg::MAX_MATRICES_DEF;
   localparam int MAX_DIMS     = MAXM + 1;
   localparam int RANDOM_ITEMS = 630;
   localparam int TAIL_START   = 530;
   localparam int PRESSURE_AT  = 300;
   localparam int DIR_ROWS     = 25;

   localparam logic [mco_pkg::COST_W-1:0] COST_CAP = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [mco_pkg::COST_W-1:0] SAT_CELL = 64'hFFFF_FFFF_FFFF_FFFF;
   localparam logic [mco_pkg::DIM_VALUE_W-1:0] DIM_MASK =
      mco_pkg::DIM_VALUE_W'((1 << mco_pkg::DIM_BITS_DEF) - 1);

   typedef struct packed {
      logic [mco_pkg::MIN_COST_W-1:0] min_cost;
      logic [mco_pkg::SPLIT_W-1:0]    best_split;
      logic [mco_pkg::STATUS_W-1:0]   status;
   } chain_result_type;

   typedef struct {
      logic [mco_pkg::DIM_VALUE_W-1:0] dim;
      int unsigned                     reps;
      bit                              last;
      bit                              typed;
      chain_result_type                res;
   } dir_row_type;

   localparam chain_result_type NO_RES = '{63'd0, 7'd0, mco_pkg::STATUS_OK};

   logic clock = 1'b0;
   logic reset = 1'b1;

   mco_req_if req_if ();
   mco_rsp_if rsp_if ();

   matrix_chain_order_cost dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_if),
      .rsp_ch (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Each multi-item row sends reps copies of dim; only the final copy carries
   // the last flag and the typed expectation.
   dir_row_type directed_rows [DIR_ROWS] = '{
      '{16'd9,     1,  1'b1, 1'b1, '{63'd0, 7'd0, mco_pkg::STATUS_NO_MATRIX}},
      '{16'hFFFF,  1,  1'b0, 1'b0, NO_RES},
      '{16'hFFFF,  1,  1'b1, 1'b1, '{63'd0, 7'd0, mco_pkg::STATUS_OK}},
      '{16'hFFFF,  2,  1'b0, 1'b0, NO_RES},
      '{16'hFFFF,  1,  1'b1, 1'b1, '{63'h0000_FFFD_0002_FFFF, 7'd1, mco_pkg::STATUS_OK}},
      '{16'd10,    1,  1'b0, 1'b0, NO_RES},
      '{16'd30,    1,  1'b0, 1'b0, NO_RES},
      '{16'd5,     1,  1'b0, 1'b0, NO_RES},
      '{16'd60,    1,  1'b1, 1'b0, NO_RES},
      '{16'h8000,  1,  1'b0, 1'b0, NO_RES},
      '{16'h0000,  1,  1'b0, 1'b0, NO_RES},
      '{16'hAAAA,  1,  1'b0, 1'b0, NO_RES},
      '{16'h5555,  1,  1'b0, 1'b0, NO_RES},
      '{16'h0001,  1,  1'b1, 1'b0, NO_RES},
      '{16'd1,     4,  1'b0, 1'b0, NO_RES},
      '{16'd1,     1,  1'b1, 1'b0, NO_RES},
      '{16'd2,     64, 1'b0, 1'b0, NO_RES},
      '{16'd3,     1,  1'b1, 1'b0, NO_RES},
      '{16'd7,     66, 1'b0, 1'b0, NO_RES},
      '{16'd5,     1,  1'b1, 1'b1, '{63'd0, 7'd0, mco_pkg::STATUS_TOO_MANY}},
      '{16'd4,     65, 1'b0, 1'b0, NO_RES},
      '{16'd4,     1,  1'b1, 1'b1, '{63'd0, 7'd0, mco_pkg::STATUS_TOO_MANY}},
      '{16'd4,     1,  1'b0, 1'b0, NO_RES},
      '{16'd6,     1,  1'b0, 1'b0, NO_RES},
      '{16'd8,     1,  1'b1, 1'b1, '{63'd192, 7'd1, mco_pkg::STATUS_OK}}
   };

   // Predictor state: the loaded chain and the interval tables.
   logic [mco_pkg::DIM_VALUE_W-1:0] chain_dims     [0:MAX_DIMS-1];
   int unsigned                     chain_len;
   bit                              chain_overflow;
   logic [mco_pkg::COST_W-1:0]      interval_cost  [1:MAXM][1:MAXM];
   logic [mco_pkg::SPLIT_W-1:0]     interval_split [1:MAXM][1:MAXM];

   chain_result_type pending_costs [$];
   int               fault_count;
   int               stall_left;
   bit               idle_on;

   function automatic void predict_chain_cost(input logic [mco_pkg::DIM_VALUE_W-1:0] d,
                                              input logic is_last,
                                              output bit produced,
                                              output chain_result_type r);
      int unsigned                n, len, i, j, k, best_k;
      logic [mco_pkg::COST_W-1:0] best, c, p, a, b;
      bit                         have;
      produced = 1'b0;
      r = NO_RES;
      if (chain_len < MAX_DIMS) begin
         chain_dims[chain_len] = d & DIM_MASK;
         chain_len++;
      end else begin
         chain_overflow = 1'b1;
      end
      if (!is_last) return;
      produced = 1'b1;
      if (chain_overflow) begin
         r.status = mco_pkg::STATUS_TOO_MANY;
      end else if (chain_len < 2) begin
         r.status = mco_pkg::STATUS_NO_MATRIX;
      end else begin
         n = chain_len - 1;
         for (i = 1; i <= n; i++) begin
            interval_cost[i][i] = '0;
            interval_split[i][i] = '0;
         end
         for (len = 2; len <= n; len++) begin
            for (i = 1; i + len - 1 <= n; i++) begin
               j = i + len - 1;
               have = 1'b0;
               best = '0;
               best_k = 0;
               for (k = i; k < j; k++) begin
                  p = 64'(chain_dims[i-1]) * 64'(chain_dims[k]) * 64'(chain_dims[j]);
                  a = interval_cost[i][k];
                  b = interval_cost[k+1][j];
                  // A saturated operand or partial sum pins the candidate at the saturated marker.
                  if (a[mco_pkg::COST_W-1] || b[mco_pkg::COST_W-1]) begin
                     c = SAT_CELL;
                  end else begin
                     c = a + b;
                     if (c > COST_CAP) begin
                        c = SAT_CELL;
                     end else begin
                        c = c + p;
                        if (c > COST_CAP) c = SAT_CELL;
                     end
                  end
                  // Strict compare keeps the smallest split among ties.
                  if (!have || c < best) begin
                     best = c;
                     best_k = k;
                     have = 1'b1;
                  end
               end
               interval_cost[i][j] = best;
               interval_split[i][j] = mco_pkg::SPLIT_W'(best_k);
            end
         end
         c = interval_cost[1][n];
         r.min_cost = c[mco_pkg::MIN_COST_W-1:0];
         r.best_split = interval_split[1][n];
         r.status = c[mco_pkg::COST_W-1] ? mco_pkg::STATUS_SATURATED : mco_pkg::STATUS_OK;
      end
      chain_len = 0;
      chain_overflow = 1'b0;
   endfunction

   task automatic report_fault(input string msg);
      fault_count++;
      if (fault_count <= 10) $display("%s", msg);
   endtask

   function automatic logic [mco_pkg::DIM_VALUE_W-1:0] pick_dim(input int mode);
      case (mode)
         0: pick_dim = mco_pkg::DIM_VALUE_W'($urandom_range(0, 65535));
         1: pick_dim = mco_pkg::DIM_VALUE_W'($urandom_range(0, 3));
         2: pick_dim = mco_pkg::DIM_VALUE_W'($urandom_range(1, 200));
         default: begin
            case ($urandom_range(0, 3))
               0: pick_dim = 16'h0000;
               1: pick_dim = 16'h0001;
               2: pick_dim = 16'h8000;
               default: pick_dim = 16'hFFFF;
            endcase
         end
      endcase
   endfunction

   // Drives one dimension item and waits for its acceptance. The valid line is left
   // high, so back-to-back items go without a gap unless a random idle gap is inserted.
   task automatic send_dim(input logic [mco_pkg::DIM_VALUE_W-1:0] d, input logic is_last,
                           input bit typed, input chain_result_type typed_res);
      bit               produced;
      chain_result_type r;
      if (idle_on && $urandom_range(0, 4) == 0) begin
         req_if.valid <= 1'b0;
         repeat ($urandom_range(1, 11)) @(posedge clock);
      end
      req_if.valid     <= 1'b1;
      req_if.dim_value <= d;
      req_if.last_dim  <= is_last;
      do @(posedge clock); while (!req_if.ready);
      predict_chain_cost(d, is_last, produced, r);
      if (produced) pending_costs.push_back(typed ? typed_res : r);
   endtask

   task automatic drain_results();
      req_if.valid <= 1'b0;
      @(posedge clock);
      while (pending_costs.size() != 0) @(posedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= 0;
      end else if (stall_left != 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= stall_left - 1;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
         rsp_if.ready <= 1'b0;
         stall_left   <= $urandom_range(0, 10);
      end else begin
         rsp_if.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin : result_check
      chain_result_type want;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_costs.size() == 0) begin
            report_fault($sformatf("unexpected result: cost %0d split %0d status %0d",
                                   rsp_if.min_cost, rsp_if.best_split, rsp_if.status));
         end else begin
            want = pending_costs.pop_front();
            if (rsp_if.min_cost !== want.min_cost || rsp_if.best_split !== want.best_split
                || rsp_if.status !== want.status) begin
               report_fault($sformatf(
                  "mismatch: cost %0d/%0d split %0d/%0d status %0d/%0d (expected/actual)",
                  want.min_cost, rsp_if.min_cost, want.best_split, rsp_if.best_split,
                  want.status, rsp_if.status));
            end
         end
      end
   end

   initial begin : stimulus
      int unsigned   rep, len, m, random_sent, big_chains, pick, mode;
      bit            pressure_done;
      logic [15:0]   d;
      req_if.valid     = 1'b0;
      req_if.dim_value = '0;
      req_if.last_dim  = 1'b0;
      chain_len        = 0;
      chain_overflow   = 1'b0;
      fault_count      = 0;
      idle_on          = 1'b1;
      random_sent      = 0;
      big_chains       = 0;
      pressure_done    = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[r]) begin
         for (rep = 0; rep < directed_rows[r].reps; rep++) begin
            send_dim(directed_rows[r].dim,
                     (rep == directed_rows[r].reps - 1) && directed_rows[r].last,
                     (rep == directed_rows[r].reps - 1) && directed_rows[r].typed,
                     directed_rows[r].res);
         end
      end
      drain_results();

      // Mostly short chains; a few large ones up to full size and some that overflow the store.
      while (random_sent < RANDOM_ITEMS) begin
         pick = $urandom_range(0, 99);
         if (pick < 8) len = 1;
         else if (pick < 78) len = $urandom_range(2, 9);
         else if (pick < 92) len = $urandom_range(10, 24);
         else if (pick >= 96) len = $urandom_range(MAX_DIMS + 1, MAX_DIMS + 5);
         else if (big_chains < 3) begin
            len = $urandom_range(40, MAX_DIMS);
            big_chains++;
         end else len = $urandom_range(2, 9);
         mode = $urandom_range(0, 3);
         idle_on <= !($urandom_range(0, 3) == 0 || random_sent >= TAIL_START);
         for (m = 0; m < len; m++) begin
            d = ($urandom_range(0, 9) == 0) ? 16'($urandom) : pick_dim(mode);
            send_dim(d, m == len - 1, 1'b0, NO_RES);
         end
         random_sent += len;
         if (!pressure_done && random_sent >= PRESSURE_AT) begin
            pressure_done = 1'b1;
            drain_results();
         end
      end

      drain_results();
      repeat (200) @(posedge clock);
      if (fault_count == 0 && pending_costs.size() == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

   initial begin
      #30_000_000;
      $display("FAIL");
      $finish;
   end

endmodule
